// ===== rtl/dcmsl_pkg.sv =====
// Shared types and constants for the dual channel motor slew limiter.
// No dependencies; every other rtl file refers to this package by scoped name.
`default_nettype none

package dcmsl_pkg;

	// Field widths
	localparam int unsigned CMD_W    = 8;
	localparam int unsigned TARGET_W = 16;
	localparam int unsigned CFG_W    = 7;
	localparam int unsigned PADDR_W  = 4;
	localparam int unsigned PDATA_W  = 32;

	// Magnitude limit used by tank and brake
	localparam logic [CFG_W-1:0] FULL_LIMIT = 7'd127;

	// Register reset values
	localparam logic [CFG_W-1:0] POWER_LIMIT_RST = 7'd127;
	localparam logic [CFG_W-1:0] ACCEL_STEP_RST  = 7'd10;
	localparam logic [CFG_W-1:0] DECEL_STEP_RST  = 7'd20;

	// Register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_POWER_LIMIT = 2'd0,
		REG_ACCEL_STEP  = 2'd1,
		REG_DECEL_STEP  = 2'd2
	} reg_idx_t;

	// Command source
	typedef enum logic [1:0] {
		MODE_PID   = 2'd0,
		MODE_TANK  = 2'd1,
		MODE_BRAKE = 2'd2
	} mode_t;

	// Configuration seen by the datapath
	typedef struct packed {
		logic [CFG_W-1:0] power_limit;
		logic [CFG_W-1:0] accel_step;
		logic [CFG_W-1:0] decel_step;
	} cfg_t;

	// One result request
	typedef struct packed {
		logic signed [CMD_W-1:0] left_command;
		logic signed [CMD_W-1:0] right_command;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/dcmsl_ifs.sv =====
// Valid/ready channel interfaces for target requests and command results.
// Depends on dcmsl_pkg for field widths.
`default_nettype none

interface dcmsl_tick_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             mode;
	logic signed [dcmsl_pkg::TARGET_W-1:0]  left_target;
	logic signed [dcmsl_pkg::TARGET_W-1:0]  right_target;

	modport source (output valid, output mode, output left_target, output right_target,
		input ready);
	modport sink (input valid, input mode, input left_target, input right_target,
		output ready);
endinterface

interface dcmsl_drive_if;
	logic                                valid;
	logic                                ready;
	logic signed [dcmsl_pkg::CMD_W-1:0]  left_command;
	logic signed [dcmsl_pkg::CMD_W-1:0]  right_command;

	modport source (output valid, output left_command, output right_command, input ready);
	modport sink (input valid, input left_command, input right_command, output ready);
endinterface

`default_nettype wire

// ===== rtl/dual_channel_motor_slew_limiter.sv =====
// Dual channel motor slew limiter: two slew lanes, a result merge buffer, APB registers.
// An accepted tick request's result is registered in the merge buffer; drive offers it from the main entry.
// Throughput: one request per cycle; a two-entry result buffer lets one more request
// in while a result waits, then tick.ready drops until drive drains.
// Reset (arst_n low, asynchronous): last commands clear to zero, buffer empties,
// registers return to power_limit 127, accel_step 10, decel_step 20.
`default_nettype none

module dual_channel_motor_slew_limiter (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [dcmsl_pkg::PADDR_W-1:0] paddr,
	input  wire logic [dcmsl_pkg::PDATA_W-1:0] pwdata,
	output logic      [dcmsl_pkg::PDATA_W-1:0] prdata,
	output logic                               pready,
	dcmsl_tick_if.sink                         tick,
	dcmsl_drive_if.source                      drive
);

	dcmsl_pkg::cfg_t                       cfg;
	logic                                  accept;
	logic                                  space;
	logic                                  brake;
	logic        [dcmsl_pkg::CFG_W-1:0]    limit;
	logic signed [dcmsl_pkg::TARGET_W-1:0] left_tgt;
	logic signed [dcmsl_pkg::TARGET_W-1:0] right_tgt;
	logic signed [dcmsl_pkg::CMD_W-1:0]    left_cmd;
	logic signed [dcmsl_pkg::CMD_W-1:0]    right_cmd;

	dcmsl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign tick.ready = space;
	assign accept     = tick.valid & space;

	// Mode decode: limit and brake override; the unused code acts as brake
	always_comb begin
		case (tick.mode)
			dcmsl_pkg::MODE_PID: begin
				brake = 1'b0;
				limit = cfg.power_limit;
			end
			dcmsl_pkg::MODE_TANK: begin
				brake = 1'b0;
				limit = dcmsl_pkg::FULL_LIMIT;
			end
			dcmsl_pkg::MODE_BRAKE: begin
				brake = 1'b1;
				limit = dcmsl_pkg::FULL_LIMIT;
			end
			default: begin
				brake = 1'b1;
				limit = dcmsl_pkg::FULL_LIMIT;
			end
		endcase
	end

	assign left_tgt  = brake ? '0 : tick.left_target;
	assign right_tgt = brake ? '0 : tick.right_target;

	dcmsl_lane u_lane_left (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (accept),
		.target     (left_tgt),
		.limit      (limit),
		.accel_step (cfg.accel_step),
		.decel_step (cfg.decel_step),
		.command    (left_cmd)
	);

	dcmsl_lane u_lane_right (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (accept),
		.target     (right_tgt),
		.limit      (limit),
		.accel_step (cfg.accel_step),
		.decel_step (cfg.decel_step),
		.command    (right_cmd)
	);

	dcmsl_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (accept),
		.left_command  (left_cmd),
		.right_command (right_cmd),
		.space         (space),
		.drive         (drive)
	);

endmodule

`default_nettype wire

// ===== rtl/dcmsl_regs.sv =====
// APB-style configuration registers: power limit, accelerate and decelerate steps.
// Depends on dcmsl_pkg.
`default_nettype none

module dcmsl_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [dcmsl_pkg::PADDR_W-1:0] paddr,
	input  wire logic [dcmsl_pkg::PDATA_W-1:0] pwdata,
	output logic      [dcmsl_pkg::PDATA_W-1:0] prdata,
	output logic                               pready,
	output dcmsl_pkg::cfg_t                    cfg
);

	dcmsl_pkg::cfg_t cfg_q;
	logic            wr_en;
	logic [1:0]      reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_limit <= dcmsl_pkg::POWER_LIMIT_RST;
			cfg_q.accel_step  <= dcmsl_pkg::ACCEL_STEP_RST;
			cfg_q.decel_step  <= dcmsl_pkg::DECEL_STEP_RST;
		end else if (wr_en) begin
			case (reg_idx)
				dcmsl_pkg::REG_POWER_LIMIT: cfg_q.power_limit <= pwdata[dcmsl_pkg::CFG_W-1:0];
				dcmsl_pkg::REG_ACCEL_STEP:  cfg_q.accel_step  <= pwdata[dcmsl_pkg::CFG_W-1:0];
				dcmsl_pkg::REG_DECEL_STEP:  cfg_q.decel_step  <= pwdata[dcmsl_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		case (reg_idx)
			dcmsl_pkg::REG_POWER_LIMIT: prdata[dcmsl_pkg::CFG_W-1:0] = cfg_q.power_limit;
			dcmsl_pkg::REG_ACCEL_STEP:  prdata[dcmsl_pkg::CFG_W-1:0] = cfg_q.accel_step;
			dcmsl_pkg::REG_DECEL_STEP:  prdata[dcmsl_pkg::CFG_W-1:0] = cfg_q.decel_step;
			default:                    prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/dcmsl_lane.sv =====
// One slew lane: holds the last command and steps it toward the target, then saturates.
// Depends on dcmsl_pkg.
`default_nettype none

module dcmsl_lane (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 en,
	input  wire logic signed [dcmsl_pkg::TARGET_W-1:0] target,
	input  wire logic        [dcmsl_pkg::CFG_W-1:0]    limit,
	input  wire logic        [dcmsl_pkg::CFG_W-1:0]    accel_step,
	input  wire logic        [dcmsl_pkg::CFG_W-1:0]    decel_step,
	output logic signed      [dcmsl_pkg::CMD_W-1:0]    command
);

	logic signed [dcmsl_pkg::CMD_W-1:0]    prev_q;
	logic signed [dcmsl_pkg::TARGET_W:0]   diff;
	logic        [dcmsl_pkg::TARGET_W:0]   diff_mag;
	logic                                  dir_neg;
	logic                                  motion_neg;
	logic        [dcmsl_pkg::CFG_W-1:0]    step;
	logic        [dcmsl_pkg::CFG_W-1:0]    move;
	logic signed [dcmsl_pkg::CMD_W:0]      prev_ext;
	logic signed [dcmsl_pkg::CMD_W:0]      move_ext;
	logic signed [dcmsl_pkg::CMD_W:0]      moved;
	logic signed [dcmsl_pkg::CMD_W:0]      lim_pos;
	logic signed [dcmsl_pkg::CMD_W:0]      lim_neg;
	logic signed [dcmsl_pkg::CMD_W:0]      sat;

	// Distance and direction to the target
	assign diff     = {target[dcmsl_pkg::TARGET_W-1], target}
		- {{(dcmsl_pkg::TARGET_W-dcmsl_pkg::CMD_W+1){prev_q[dcmsl_pkg::CMD_W-1]}}, prev_q};
	assign dir_neg  = diff[dcmsl_pkg::TARGET_W];
	assign diff_mag = dir_neg ? (dcmsl_pkg::TARGET_W+1)'(-diff) : diff;

	// Speeding up when moving the same way as the current motion; from zero the target's sign gives the motion
	assign motion_neg = (prev_q == '0) ? target[dcmsl_pkg::TARGET_W-1]
	                                   : prev_q[dcmsl_pkg::CMD_W-1];
	assign step       = (dir_neg == motion_neg) ? accel_step : decel_step;
	assign move       = (diff_mag > (dcmsl_pkg::TARGET_W+1)'(step)) ? step
	                                                               : diff_mag[dcmsl_pkg::CFG_W-1:0];

	// Step, then clamp magnitude to the limit
	assign prev_ext = {prev_q[dcmsl_pkg::CMD_W-1], prev_q};
	assign move_ext = {2'b00, move};
	assign moved    = dir_neg ? prev_ext - move_ext : prev_ext + move_ext;
	assign lim_pos  = {2'b00, limit};
	assign lim_neg  = -lim_pos;

	always_comb begin
		if (moved > lim_pos) begin
			sat = lim_pos;
		end else if (moved < lim_neg) begin
			sat = lim_neg;
		end else begin
			sat = moved;
		end
	end

	assign command = sat[dcmsl_pkg::CMD_W-1:0];

	// Last command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (en) begin
			prev_q <= command;
		end
	end

`ifndef SYNTHESIS
	// The held command never reaches the most negative code
	a_prev_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		prev_q != {1'b1, {(dcmsl_pkg::CMD_W-1){1'b0}}})
		else $error("lane command left the -127..127 range");
`endif

endmodule

`default_nettype wire

// ===== rtl/dcmsl_merge.sv =====
// Merges the two lane commands into one result and buffers it (main plus skid entry).
// Depends on dcmsl_pkg and dcmsl_drive_if.
`default_nettype none

module dcmsl_merge (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	input  wire logic signed [dcmsl_pkg::CMD_W-1:0] left_command,
	input  wire logic signed [dcmsl_pkg::CMD_W-1:0] right_command,
	output logic                                   space,
	dcmsl_drive_if.source                          drive
);

	dcmsl_pkg::result_t main_q;
	dcmsl_pkg::result_t skid_q;
	dcmsl_pkg::result_t incoming;
	logic               main_vld_q;
	logic               skid_vld_q;
	logic               pop;

	assign incoming.left_command  = left_command;
	assign incoming.right_command = right_command;

	assign pop   = main_vld_q & drive.ready;
	assign space = ~skid_vld_q;

	assign drive.valid         = main_vld_q;
	assign drive.left_command  = main_q.left_command;
	assign drive.right_command = main_q.right_command;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				main_vld_q <= push;
			end
		end else if (push) begin
			if (main_vld_q) begin
				skid_vld_q <= 1'b1;
			end else begin
				main_vld_q <= 1'b1;
			end
		end
	end

	// Result data
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_vld_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= incoming;
			end
		end else if (push) begin
			if (main_vld_q) begin
				skid_q <= incoming;
			end else begin
				main_q <= incoming;
			end
		end
	end

`ifndef SYNTHESIS
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> main_vld_q)
		else $error("skid entry held without a main entry");
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_vld_q)
		else $error("result request pushed into a full buffer");
	a_skid_moves_up: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && pop) |=> (main_vld_q && !skid_vld_q))
		else $error("skid entry lost on drain");
`endif

endmodule

`default_nettype wire
